/* rtl/rbcf_pkg.sv */
// shared types and constants for the ring buffer claim/finish index manager
`default_nettype none

package rbcf_pkg;

  // default width of the wrapping indices
  localparam int INDEX_WIDTH_DEF = 16;

  // buffer size after reset, before clamping
  localparam int BUF_SIZE_RESET = 1024;

  // largest buffer size the byte offsets can express
  localparam int BUF_SIZE_MAX = 32768;

  // operation selector carried on the input tuser
  typedef enum logic [1:0] {
    FUNC_PUT_CLAIM  = 2'd0,
    FUNC_PUT_FINISH = 2'd1,
    FUNC_GET_CLAIM  = 2'd2,
    FUNC_GET_FINISH = 2'd3
  } func_t;

  // result word, first field in the highest bits
  typedef struct packed {
    logic [15:0] ready_count;
    logic [15:0] free_space;
    logic        finish_error;
    logic [14:0] area_offset;
    logic [15:0] granted_length;
  } res_t;

endpackage

`default_nettype wire

/* rtl/ring_buffer_claim_finish_index.sv */
// Pipeline: two register stages; an accepted word waits in the input register, its
// result word in the result register until taken. Throughput: one word per cycle
// while the sink takes words; the index registers update as a word moves on.
// Reset (rst_n low, synchronous): all indices clear to zero, the buffer size
// returns to 1024 clamped to the index range, both channels empty.
`default_nettype none

module ring_buffer_claim_finish_index import rbcf_pkg::*; #(
  parameter int INDEX_WIDTH = INDEX_WIDTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // configuration: buffer size
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_wdata,   // buffer_size
  // operation channel
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,    // request_length
  input  wire logic [1:0]  in_tuser,    // func
  // result channel
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [63:0]      out_tdata    // granted_length, area_offset, finish_error,
                                        // free_space, ready_count
);

  localparam int IW     = INDEX_WIDTH;
  localparam int SZW    = (IW < 16) ? IW : 16;
  localparam int CAP_I  = (IW - 1 >= 15) ? BUF_SIZE_MAX : (1 << (IW - 1));
  localparam int SZ0_I  = (BUF_SIZE_RESET > CAP_I) ? CAP_I : BUF_SIZE_RESET;
  localparam logic [15:0]    CAP16  = 16'(CAP_I);
  localparam logic [SZW-1:0] SZ_RST = SZW'(SZ0_I);

  logic [SZW-1:0] size_r;
  logic [15:0]    size_clamp;

  logic           in_valid_r;
  func_t          func_r;
  logic [15:0]    len_r;

  logic           out_valid_r;
  res_t           res_r;
  res_t           res_nxt;

  logic           out_free, advance;

  logic [IW-1:0] p_head_r, p_tail_r, p_base_r, c_head_r, c_tail_r, c_base_r;
  logic [IW-1:0] p_head_nxt, p_tail_nxt, p_base_nxt;
  logic [IW-1:0] c_head_nxt, c_tail_nxt, c_base_nxt;

  // clamp written size into the usable range
  always_comb begin
    if (cfg_wdata == 16'd0) begin
      size_clamp = 16'd1;
    end else if (cfg_wdata > CAP16) begin
      size_clamp = CAP16;
    end else begin
      size_clamp = cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= SZ_RST;
    end else if (cfg_we) begin
      size_r <= SZW'(size_clamp);
    end
  end

  // handshake between the two register stages
  assign out_free  = !out_valid_r || out_tready;
  assign advance   = in_valid_r && out_free;
  assign in_tready = !in_valid_r || out_free;

  // input register control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  // input register payload
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      func_r <= func_t'(in_tuser);
      len_r  <= in_tdata;
    end
  end

  rbcf_step #(
    .INDEX_WIDTH (IW),
    .SIZE_WIDTH  (SZW)
  ) u_step (
    .func           (func_r),
    .request_length (len_r),
    .size           (size_r),
    .p_head         (p_head_r),
    .p_tail         (p_tail_r),
    .p_base         (p_base_r),
    .c_head         (c_head_r),
    .c_tail         (c_tail_r),
    .c_base         (c_base_r),
    .p_head_nxt     (p_head_nxt),
    .p_tail_nxt     (p_tail_nxt),
    .p_base_nxt     (p_base_nxt),
    .c_head_nxt     (c_head_nxt),
    .c_tail_nxt     (c_tail_nxt),
    .c_base_nxt     (c_base_nxt),
    .res            (res_nxt)
  );

  // index registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_head_r <= '0;
      p_tail_r <= '0;
      p_base_r <= '0;
      c_head_r <= '0;
      c_tail_r <= '0;
      c_base_r <= '0;
    end else if (advance) begin
      p_head_r <= p_head_nxt;
      p_tail_r <= p_tail_nxt;
      p_base_r <= p_base_nxt;
      c_head_r <= c_head_nxt;
      c_tail_r <= c_tail_nxt;
      c_base_r <= c_base_nxt;
    end
  end

  // result register control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= in_valid_r;
    end
  end

  // result register payload
  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = res_r;

endmodule

`default_nettype wire

/* rtl/rbcf_step.sv */
// next index state and result word for one claim or finish operation
`default_nettype none

module rbcf_step import rbcf_pkg::*; #(
  parameter int INDEX_WIDTH = INDEX_WIDTH_DEF,
  parameter int SIZE_WIDTH  = 16
) (
  input  wire func_t                   func,
  input  wire logic [15:0]             request_length,
  input  wire logic [SIZE_WIDTH-1:0]   size,
  input  wire logic [INDEX_WIDTH-1:0]  p_head,
  input  wire logic [INDEX_WIDTH-1:0]  p_tail,
  input  wire logic [INDEX_WIDTH-1:0]  p_base,
  input  wire logic [INDEX_WIDTH-1:0]  c_head,
  input  wire logic [INDEX_WIDTH-1:0]  c_tail,
  input  wire logic [INDEX_WIDTH-1:0]  c_base,
  output logic      [INDEX_WIDTH-1:0]  p_head_nxt,
  output logic      [INDEX_WIDTH-1:0]  p_tail_nxt,
  output logic      [INDEX_WIDTH-1:0]  p_base_nxt,
  output logic      [INDEX_WIDTH-1:0]  c_head_nxt,
  output logic      [INDEX_WIDTH-1:0]  c_tail_nxt,
  output logic      [INDEX_WIDTH-1:0]  c_base_nxt,
  output res_t                         res
);

  localparam int IW = INDEX_WIDTH;
  // compare width wide enough for both the request and an index difference
  localparam int LW = (IW > 16) ? IW : 16;

  logic [IW-1:0] sz;
  logic [IW-1:0] alloc_now, free_now, rdy_raw_now, ready_now;
  logic          is_get;
  logic [IW-1:0] side_head, side_tail, side_base;
  logic [IW-1:0] avail, want;
  logic [IW-1:0] off0, off1, wrap, grant, head_adv;
  logic          no_room;
  logic [IW-1:0] claimed, tail_adv, toff, base_adv;
  logic          fin_err;
  logic [IW-1:0] alloc_nxt, free_nxt, rdy_raw_nxt, ready_nxt;

  assign sz = IW'(size);

  // free space and committed data before the operation
  assign alloc_now   = p_head - c_tail;
  assign free_now    = (alloc_now > sz) ? '0 : (sz - alloc_now);
  assign rdy_raw_now = p_tail - c_head;
  assign ready_now   = (rdy_raw_now > sz) ? '0 : rdy_raw_now;

  // side selected by the operation
  assign is_get    = func[1];
  assign side_head = is_get ? c_head : p_head;
  assign side_tail = is_get ? c_tail : p_tail;
  assign side_base = is_get ? c_base : p_base;

  // claim: limit by space or data, by request and by the wrap point
  assign avail    = is_get ? ready_now : free_now;
  assign want     = (LW'(request_length) < LW'(avail)) ? IW'(request_length) : avail;
  assign off0     = side_head - side_base;
  assign off1     = (off0 >= sz) ? (off0 - sz) : off0;
  assign no_room  = (off1 >= sz);
  assign wrap     = sz - off1;
  assign grant    = no_room ? '0 : ((want > wrap) ? wrap : want);
  assign head_adv = side_head + grant;

  // finish: commit length, pull head back, move base past the wrap point
  assign claimed  = side_head - side_tail;
  assign fin_err  = (LW'(request_length) > LW'(claimed));
  assign tail_adv = side_tail + IW'(request_length);
  assign toff     = tail_adv - side_base;
  assign base_adv = (toff >= sz) ? (side_base + sz) : side_base;

  // next index state
  always_comb begin
    p_head_nxt = p_head;
    p_tail_nxt = p_tail;
    p_base_nxt = p_base;
    c_head_nxt = c_head;
    c_tail_nxt = c_tail;
    c_base_nxt = c_base;
    case (func)
      FUNC_PUT_CLAIM: begin
        p_head_nxt = head_adv;
      end
      FUNC_PUT_FINISH: begin
        if (!fin_err) begin
          p_tail_nxt = tail_adv;
          p_head_nxt = tail_adv;
          p_base_nxt = base_adv;
        end
      end
      FUNC_GET_CLAIM: begin
        c_head_nxt = head_adv;
      end
      FUNC_GET_FINISH: begin
        if (!fin_err) begin
          c_tail_nxt = tail_adv;
          c_head_nxt = tail_adv;
          c_base_nxt = base_adv;
        end
      end
      default: begin
        p_head_nxt = p_head;
      end
    endcase
  end

  // levels after the operation
  assign alloc_nxt   = p_head_nxt - c_tail_nxt;
  assign free_nxt    = (alloc_nxt > sz) ? '0 : (sz - alloc_nxt);
  assign rdy_raw_nxt = p_tail_nxt - c_head_nxt;
  assign ready_nxt   = (rdy_raw_nxt > sz) ? '0 : rdy_raw_nxt;

  // result word
  always_comb begin
    res.ready_count = 16'(ready_nxt);
    res.free_space  = 16'(free_nxt);
    if (func == FUNC_PUT_CLAIM || func == FUNC_GET_CLAIM) begin
      res.granted_length = 16'(grant);
      res.area_offset    = no_room ? '0 : 15'(off1);
      res.finish_error   = 1'b0;
    end else begin
      res.granted_length = '0;
      res.area_offset    = '0;
      res.finish_error   = fin_err;
    end
  end

endmodule

`default_nettype wire

/* rtl/rbcf_checker.sv */
// port-level checks for the ring buffer claim/finish index manager
`default_nettype none

module rbcf_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [63:0] out_tdata
);

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word changed while stalled");

  // an accepted word reaches the output through both register stages when the sink stays ready
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && out_tready) ##1 out_tready |=> out_tvalid)
    else $error("result word missing two cycles after accept");

  // a finish error never comes with a granted area
  a_err_no_grant: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[31] |-> out_tdata[15:0] == 16'd0 && out_tdata[30:16] == 15'd0)
    else $error("finish error with non-zero grant");

  // levels and the granted length never exceed the largest buffer size
  a_levels: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[47:32] <= 16'd32768 && out_tdata[63:48] <= 16'd32768
                   && out_tdata[15:0] <= 16'd32768)
    else $error("level above buffer size");

  // output empty after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind ring_buffer_claim_finish_index rbcf_checker u_rbcf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire

/* tb/ring_buffer_claim_finish_index_tb.sv */
// self-checking testbench for the ring buffer claim/finish index manager
`timescale 1ns / 100ps

module ring_buffer_claim_finish_index_tb import rbcf_pkg::*;;

  // tracks both index sets and the buffer size, predicts every result word
  class index_tracker;
    logic [15:0] p_head, p_tail, p_base;
    logic [15:0] c_head, c_tail, c_base;
    logic [15:0] size_reg;
    res_t        pending_words[$];
    int          mismatches;

    function new();
      p_head = '0; p_tail = '0; p_base = '0;
      c_head = '0; c_tail = '0; c_base = '0;
      size_reg = 16'(BUF_SIZE_RESET);
      mismatches = 0;
    endfunction

    // size in use, clamped to what the offsets can express
    function int unsigned eff_size();
      if (size_reg == 16'd0) return 1;
      if (size_reg > BUF_SIZE_MAX) return BUF_SIZE_MAX;
      return 32'(size_reg);
    endfunction

    function int unsigned free_bytes(int unsigned sz);
      logic [15:0] alloc;
      alloc = p_head - c_tail;
      return (32'(alloc) > sz) ? 0 : sz - 32'(alloc);
    endfunction

    function int unsigned ready_bytes(int unsigned sz);
      logic [15:0] avail;
      avail = p_tail - c_head;
      return (32'(avail) > sz) ? 0 : 32'(avail);
    endfunction

    // contiguous grant up to the wrap point, head moves on by the grant
    function int unsigned grab(inout logic [15:0] head, input logic [15:0] base,
                               input int unsigned sz, input int unsigned want,
                               output int unsigned offset);
      logic [15:0] diff;
      int unsigned off;
      diff = head - base;
      off = 32'(diff);
      if (off >= sz) off = off - sz;
      if (off >= sz) begin
        offset = 0;
        return 0;
      end
      if (want > sz - off) want = sz - off;
      offset = off;
      head = head + want[15:0];
      return want;
    endfunction

    // commit len bytes, refuse anything beyond the claimed amount
    function bit commit(inout logic [15:0] head, inout logic [15:0] tail,
                        inout logic [15:0] base, input int unsigned sz,
                        input logic [15:0] len);
      logic [15:0] claimed;
      logic [15:0] toff;
      claimed = head - tail;
      if (len > claimed) return 1'b0;
      tail = tail + len;
      head = tail;
      toff = tail - base;
      if (32'(toff) >= sz) base = base + sz[15:0];
      return 1'b1;
    endfunction

    // accepted operation word: update indices and queue the expected result
    function void note_op(func_t f, logic [15:0] len);
      res_t        w;
      int unsigned sz, want, granted, offset;
      sz = eff_size();
      granted = 0;
      offset = 0;
      w = '0;
      case (f)
        FUNC_PUT_CLAIM: begin
          want = free_bytes(sz);
          if (32'(len) < want) want = 32'(len);
          granted = grab(p_head, p_base, sz, want, offset);
        end
        FUNC_PUT_FINISH: w.finish_error = !commit(p_head, p_tail, p_base, sz, len);
        FUNC_GET_CLAIM: begin
          want = ready_bytes(sz);
          if (32'(len) < want) want = 32'(len);
          granted = grab(c_head, c_base, sz, want, offset);
        end
        default: w.finish_error = !commit(c_head, c_tail, c_base, sz, len);
      endcase
      w.granted_length = granted[15:0];
      w.area_offset    = offset[14:0];
      w.free_space     = 16'(free_bytes(sz));
      w.ready_count    = 16'(ready_bytes(sz));
      pending_words.push_back(w);
    endfunction

    function void cmp_field(string name, logic [15:0] exp_val, logic [15:0] got_val);
      if (got_val !== exp_val) begin
        mismatches++;
        $display("%0t: %s expected %0d actual %0d", $time, name, exp_val, got_val);
      end
    endfunction

    // accepted result word against the oldest expectation
    function void check_word(res_t got);
      res_t exp_w;
      if (pending_words.size() == 0) begin
        mismatches++;
        $display("%0t: result word with none expected, expected nothing actual %h",
                 $time, got);
        return;
      end
      exp_w = pending_words.pop_front();
      cmp_field("granted_length", exp_w.granted_length, got.granted_length);
      cmp_field("area_offset", 16'(exp_w.area_offset), 16'(got.area_offset));
      cmp_field("finish_error", 16'(exp_w.finish_error), 16'(got.finish_error));
      cmp_field("free_space", exp_w.free_space, got.free_space);
      cmp_field("ready_count", exp_w.ready_count, got.ready_count);
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [15:0] cfg_wdata;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;   // request_length
  logic [1:0]  in_tuser;   // func
  logic        out_tvalid;
  logic        out_tready;
  logic [63:0] out_tdata;  // granted_length, area_offset, finish_error,
                           // free_space, ready_count

  index_tracker tracker;
  bit           tx_idle_en;
  bit           rx_idle_en;
  int           rx_hold;

  ring_buffer_claim_finish_index dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // 20 ns clock
  always #10 clk = ~clk;

  // offer one operation word, hold it until taken, then maybe go quiet
  task automatic push_op(func_t f, logic [15:0] len);
    in_tvalid <= 1'b1;
    in_tuser  <= f;
    in_tdata  <= len;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    tracker.note_op(f, len);
    if (tx_idle_en && $urandom_range(0, 7) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
  endtask

  // stop offering and wait for every outstanding result
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (tracker.pending_words.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // buffer size write, only with the block idle
  task automatic set_size(logic [15:0] value);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    tracker.size_reg = value;
    @(posedge clk);
  endtask

  function automatic logic [15:0] claim_len(int unsigned sz);
    int unsigned top;
    top = sz + sz / 2;
    if (top > 65535) top = 65535;
    case ($urandom_range(0, 9))
      0: return 16'($urandom_range(0, 65535));
      1: return 16'd0;
      default: return 16'($urandom_range(1, top));
    endcase
  endfunction

  function automatic logic [15:0] finish_len(logic [15:0] claimed);
    case ($urandom_range(0, 7))
      0: return claimed + 16'd1;
      1: return 16'd0;
      2, 3: return claimed;
      default: return 16'($urandom_range(0, 32'(claimed)));
    endcase
  endfunction

  // mostly claim/finish pairs sized from the current indices, some noise
  task automatic run_traffic(int n);
    int unsigned sz, pick;
    logic [15:0] len;
    func_t       f;
    for (int i = 0; i < n; i++) begin
      sz   = tracker.eff_size();
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        f   = FUNC_PUT_CLAIM;
        len = claim_len(sz);
      end else if (pick < 55) begin
        f   = FUNC_PUT_FINISH;
        len = finish_len(tracker.p_head - tracker.p_tail);
      end else if (pick < 75) begin
        f   = FUNC_GET_CLAIM;
        len = claim_len(sz);
      end else if (pick < 92) begin
        f   = FUNC_GET_FINISH;
        len = finish_len(tracker.c_head - tracker.c_tail);
      end else begin
        f   = func_t'($urandom_range(0, 3));
        len = 16'($urandom_range(0, 65535));
      end
      push_op(f, len);
    end
  endtask

  // result side: check each word taken, stall in random bursts or on request
  initial begin
    int rx_gap;
    rx_gap = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) tracker.check_word(res_t'(out_tdata));
      if (rx_hold > 0) begin
        rx_gap  = rx_hold;
        rx_hold = 0;
      end
      if (rx_gap > 0) begin
        rx_gap--;
        out_tready <= 1'b0;
      end else if (rx_idle_en && $urandom_range(0, 9) == 0) begin
        rx_gap = $urandom_range(0, 17);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // run limit
  initial begin
    #(20_000_000);
    $display("[FAIL] regression broken");
    $finish;
  end

  // stimulus
  initial begin
    tracker    = new();
    clk        = 1'b0;
    rst_n      = 1'b0;
    cfg_we     = 1'b0;
    cfg_wdata  = '0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = FUNC_PUT_CLAIM;
    out_tready = 1'b0;
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    rx_hold    = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed at the reset size: empty, full, errors, partial commits, wrap
    push_op(FUNC_PUT_CLAIM, 16'd0);
    push_op(FUNC_GET_CLAIM, 16'd10);
    push_op(FUNC_GET_FINISH, 16'd1);
    push_op(FUNC_PUT_CLAIM, 16'hffff);
    push_op(FUNC_PUT_CLAIM, 16'd5);
    push_op(FUNC_PUT_FINISH, 16'hffff);
    push_op(FUNC_PUT_FINISH, 16'd1000);
    push_op(FUNC_PUT_CLAIM, 16'd100);
    push_op(FUNC_PUT_FINISH, 16'd24);
    push_op(FUNC_GET_CLAIM, 16'hffff);
    push_op(FUNC_GET_FINISH, 16'd500);
    push_op(FUNC_PUT_CLAIM, 16'd300);
    push_op(FUNC_PUT_FINISH, 16'd0);
    push_op(FUNC_PUT_CLAIM, 16'd500);
    push_op(FUNC_PUT_FINISH, 16'd500);
    push_op(FUNC_GET_CLAIM, 16'd600);
    push_op(FUNC_GET_FINISH, 16'd524);
    push_op(FUNC_GET_CLAIM, 16'd500);
    push_op(FUNC_GET_FINISH, 16'd501);
    push_op(FUNC_GET_FINISH, 16'd500);

    // small ring, lots of wrapping
    set_size(16'd16);
    run_traffic(400);

    // size extremes, zero clamps up and all-ones clamps down
    set_size(16'd0);
    run_traffic(120);
    set_size(16'd1);
    run_traffic(120);
    set_size(16'h8000);
    run_traffic(250);
    set_size(16'hffff);
    run_traffic(120);

    // shrink while data is held, leaves indices beyond the wrap point
    set_size(16'd100);
    run_traffic(150);
    set_size(16'd7);
    run_traffic(150);

    // long result back-pressure with the sender flat out, then a full drain
    set_size(16'd50);
    tx_idle_en = 1'b0;
    rx_hold    = 300;
    run_traffic(60);
    wait_drained();
    tx_idle_en = 1'b1;
    run_traffic(200);

    // closing stretch at the reset size with no idling
    set_size(16'd1024);
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    run_traffic(250);

    wait_drained();
    repeat (10) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.pending_words.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
